// File: sv/gcol_pkg.sv
// ----------------------------------------------------------------------------
// gcol_pkg
// Shared sizes and codes for the greedy graph coloring engine.
// ----------------------------------------------------------------------------
package gcol_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MAX_DEGREE   = 16;

    localparam int VTX_W  = 8;                      // vertex index width
    localparam int DEG_W  = 5;                      // holds 0..MAX_DEGREE
    localparam int SLOT_W = 4;                      // slot within a list
    localparam int COL_W  = 5;                      // holds 0..MAX_DEGREE+1
    localparam int ADJ_DEPTH = MAX_VERTICES * MAX_DEGREE;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ADD_EDGE  = 2'd0;
    localparam t_kind KIND_NEW_PASS  = 2'd1;
    localparam t_kind KIND_COLOR     = 2'd2;
    localparam t_kind KIND_CLEAR     = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_RANGE = 2'd2;

    localparam logic [2:0] ADDR_VERTEX_COUNT = 3'd0;
    localparam logic [8:0] VERTEX_COUNT_RESET = 9'd256;

endpackage

// File: sv/gcol_ram.sv
// ----------------------------------------------------------------------------
// gcol_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gcol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/greedy_graph_coloring.sv
// ----------------------------------------------------------------------------
// greedy_graph_coloring
// First-fit greedy coloring engine over a bounded-degree adjacency store.
// ----------------------------------------------------------------------------
// Each request is one of four kinds. Add edge appends each endpoint to the
// other's adjacency list (status 2 when an endpoint is at or above the vertex
// limit, status 1 when a list has no room); it runs as two reads through the
// single read port of the degree memory, then the two list writes.
// Color vertex gives the vertex the smallest color in 1..degree+1 that no
// neighbor holds; the neighbor scan streams one list entry a cycle through
// the adjacency memory and then the color memory.
// New pass and clear graph drop colors (and, for clear, degrees) at once
// through per-vertex valid bits, so there is no clearing sweep after reset.
// One result is produced per request and is held in an output register, so
// a new request is taken while a result still waits.
// The vertex limit register lies at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module greedy_graph_coloring (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  gcol_pkg::t_kind         i_kind,
    input  logic [7:0]              i_vertex_a,
    input  logic [7:0]              i_vertex_b,
    // result channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output gcol_pkg::t_status       o_status,
    output logic [4:0]              o_color,
    output logic [4:0]              o_colors_used,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import gcol_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_E_RDB, S_E_CHK, S_E_WA, S_E_WB,
        S_C_DEG, S_C_SCAN, S_C_PICK, S_FIN
    } t_state;

    t_state                r_state;
    logic [8:0]            r_vcount;
    logic [VTX_W-1:0]      r_a, r_b;
    logic [DEG_W-1:0]      r_deg_a, r_deg_b;
    logic [DEG_W-1:0]      r_iss;
    logic                  r_p1, r_p2;
    logic [VTX_W-1:0]      r_col_addr;
    logic [MAX_DEGREE-1:0] r_taken;
    logic [COL_W-1:0]      r_pass;
    logic [MAX_VERTICES-1:0] r_deg_vld, r_col_vld;
    t_status               r_res_status;
    logic [COL_W-1:0]      r_res_color;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [COL_W-1:0]      r_out_color, r_out_used;

    // memory ports
    logic                  deg_we, adj_we, col_we;
    logic [VTX_W-1:0]      deg_waddr, deg_raddr, col_waddr, col_raddr;
    logic [DEG_W-1:0]      deg_wdata, deg_q;
    logic [VTX_W+SLOT_W-1:0] adj_waddr, adj_raddr;
    logic [VTX_W-1:0]      adj_wdata, adj_q;
    logic [COL_W-1:0]      col_wdata, col_q;

    logic                  accept, out_free, issue;
    logic [8:0]            limit;
    logic                  a_bad, b_bad;
    logic [DEG_W-1:0]      deg_eff, deg_b_adj;
    logic [COL_W-1:0]      col_eff, pick;

    assign limit   = (r_vcount < 9'(MAX_VERTICES)) ? r_vcount : 9'(MAX_VERTICES);
    assign a_bad   = {1'b0, i_vertex_a} >= limit;
    assign b_bad   = {1'b0, i_vertex_b} >= limit;
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign issue   = (r_iss < r_deg_a);
    assign col_eff = r_col_vld[r_col_addr] ? col_q : '0;
    // a self loop sees its own first append before the second
    assign deg_b_adj = (r_a == r_b) ? r_deg_a + DEG_W'(1) : r_deg_b;

    always_comb begin
        unique case (r_state)
            S_E_RDB, S_E_CHK: deg_eff = r_deg_vld[(r_state == S_E_RDB) ? r_a : r_b]
                                        ? deg_q : '0;
            default:          deg_eff = r_deg_vld[r_a] ? deg_q : '0;
        endcase
    end

    // first-fit search: lowest color up to the degree that no neighbor holds, else degree+1
    always_comb begin
        pick = r_deg_a + COL_W'(1);
        for (int k = MAX_DEGREE; k >= 1; k--) begin
            if (COL_W'(k) <= r_deg_a && !r_taken[k-1]) begin
                pick = COL_W'(k);
            end
        end
    end

    always_comb begin
        deg_raddr = (r_state == S_E_RDB) ? r_b : i_vertex_a;
        deg_we    = (r_state == S_E_WA) || (r_state == S_E_WB);
        deg_waddr = (r_state == S_E_WB) ? r_b : r_a;
        deg_wdata = (r_state == S_E_WB) ? r_deg_b + DEG_W'(1) : r_deg_a + DEG_W'(1);
        adj_we    = deg_we;
        adj_waddr = (r_state == S_E_WB) ? {r_b, r_deg_b[SLOT_W-1:0]}
                                        : {r_a, r_deg_a[SLOT_W-1:0]};
        adj_wdata = (r_state == S_E_WB) ? r_a : r_b;
        adj_raddr = {r_a, r_iss[SLOT_W-1:0]};
        col_raddr = adj_q;
        col_we    = (r_state == S_C_PICK);
        col_waddr = r_a;
        col_wdata = pick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= VERTEX_COUNT_RESET;
            r_deg_vld   <= '0;
            r_col_vld   <= '0;
            r_pass      <= '0;
            r_out_valid <= 1'b0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == ADDR_VERTEX_COUNT[2]) begin
                r_vcount <= pwdata[8:0];
            end
            // drop a taken result; the finish state refills the register
            if (r_out_valid && !i_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_a <= i_vertex_a;
                        r_b <= i_vertex_b;
                        r_res_color  <= '0;
                        unique case (i_kind)
                            KIND_ADD_EDGE: begin
                                if (a_bad || b_bad) begin
                                    r_res_status <= STATUS_RANGE;
                                    r_state <= S_FIN;
                                end else begin
                                    r_res_status <= STATUS_OK;
                                    r_state <= S_E_RDB;
                                end
                            end
                            KIND_NEW_PASS: begin
                                r_res_status <= STATUS_OK;
                                r_col_vld <= '0;
                                r_pass    <= '0;
                                r_state   <= S_FIN;
                            end
                            KIND_COLOR: begin
                                if (a_bad) begin
                                    r_res_status <= STATUS_RANGE;
                                    r_state <= S_FIN;
                                end else begin
                                    r_res_status <= STATUS_OK;
                                    r_state <= S_C_DEG;
                                end
                            end
                            KIND_CLEAR: begin
                                r_res_status <= STATUS_OK;
                                r_deg_vld <= '0;
                                r_col_vld <= '0;
                                r_pass    <= '0;
                                r_state   <= S_FIN;
                            end
                            default: begin
                                r_res_status <= STATUS_OK;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_E_RDB: begin
                    r_deg_a <= deg_eff;
                    r_state <= S_E_CHK;
                end
                S_E_CHK: begin
                    r_deg_b <= deg_eff;
                    if (r_a == r_b ? (r_deg_a > DEG_W'(MAX_DEGREE - 2))
                                   : (r_deg_a >= DEG_W'(MAX_DEGREE) ||
                                      deg_eff >= DEG_W'(MAX_DEGREE))) begin
                        r_res_status <= STATUS_FULL;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_E_WA;
                    end
                end
                S_E_WA: begin
                    r_deg_vld[r_a] <= 1'b1;
                    r_deg_b <= deg_b_adj;
                    r_state <= S_E_WB;
                end
                S_E_WB: begin
                    r_deg_vld[r_b] <= 1'b1;
                    r_state <= S_FIN;
                end
                S_C_DEG: begin
                    r_deg_a <= deg_eff;
                    r_iss   <= '0;
                    r_p1    <= 1'b0;
                    r_p2    <= 1'b0;
                    r_taken <= '0;
                    r_state <= S_C_SCAN;
                end
                S_C_SCAN: begin
                    // list read, then neighbor color read, then mark
                    if (issue) begin
                        r_iss <= r_iss + DEG_W'(1);
                    end
                    r_p1 <= issue;
                    r_p2 <= r_p1;
                    r_col_addr <= adj_q;
                    if (r_p2 && col_eff != '0 && col_eff <= r_deg_a) begin
                        r_taken[SLOT_W'(col_eff - COL_W'(1))] <= 1'b1;
                    end
                    if (!issue && !r_p1 && !r_p2) begin
                        r_state <= S_C_PICK;
                    end
                end
                S_C_PICK: begin
                    r_col_vld[r_a] <= 1'b1;
                    r_res_color <= pick;
                    if (pick > r_pass) begin
                        r_pass <= pick;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_color  <= r_res_color;
                        r_out_used   <= r_pass;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    gcol_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .i_clk(i_clk), .i_we(deg_we), .i_waddr(deg_waddr), .i_wdata(deg_wdata),
        .i_raddr(deg_raddr), .o_rdata(deg_q)
    );

    gcol_ram #(.WIDTH(VTX_W), .DEPTH(ADJ_DEPTH)) u_adj_ram (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_q)
    );

    gcol_ram #(.WIDTH(COL_W), .DEPTH(MAX_VERTICES)) u_col_ram (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(col_waddr), .i_wdata(col_wdata),
        .i_raddr(col_raddr), .o_rdata(col_q)
    );

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_color       = r_out_color;
    assign o_colors_used = r_out_used;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == ADDR_VERTEX_COUNT[2]) ? {23'd0, r_vcount} : 32'd0;

    a_color_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_color <= COL_W'(MAX_DEGREE + 1))
        else $error("color above degree bound");
    a_error_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STATUS_OK |-> o_color == '0)
        else $error("failed request carries a color");
    a_color_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_color <= o_colors_used)
        else $error("color above pass maximum");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_C_SCAN |-> r_iss <= r_deg_a)
        else $error("scan ran past list end");

endmodule

// File: tb/greedy_graph_coloring_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_graph_coloring_test
// Self-checking bench for the greedy coloring engine: a directed table of
// requests followed by random graph building and coloring passes, checked
// against a behavioral predictor, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module greedy_graph_coloring_test;
    import gcol_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    t_kind             i_kind = KIND_NEW_PASS;
    logic [7:0]        i_vertex_a = '0;
    logic [7:0]        i_vertex_b = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    t_status           o_status;
    logic [4:0]        o_color;
    logic [4:0]        o_colors_used;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    greedy_graph_coloring DUT (.*);

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    typedef struct packed {
        t_status    status;
        logic [4:0] color;
        logic [4:0] used;
    } t_outcome;

    // Predictor state
    logic [8:0] vlimit;
    logic [4:0] degree [MAX_VERTICES];
    logic [7:0] nbr [MAX_VERTICES][MAX_DEGREE];
    logic [4:0] vcolor [MAX_VERTICES];
    logic [4:0] pass_hi;

    t_outcome   expected_q [$];
    int         errors = 0;

    function automatic int cur_limit();
        return (vlimit < MAX_VERTICES) ? int'(vlimit) : MAX_VERTICES;
    endfunction

    function automatic void drop_colors();
        foreach (vcolor[i]) vcolor[i] = '0;
        pass_hi = '0;
    endfunction

    // Work out the outcome of one request and advance the model state.
    function automatic t_outcome color_engine(t_kind k, logic [7:0] a, logic [7:0] b);
        t_outcome r;
        int lim, deg, c, n;
        bit taken [MAX_DEGREE + 2];
        r = '0;
        lim = cur_limit();
        case (k)
            KIND_ADD_EDGE: begin
                if (a >= lim || b >= lim) r.status = STATUS_RANGE;
                else if (a == b && degree[a] + 2 > MAX_DEGREE) r.status = STATUS_FULL;
                else if (a != b && (degree[a] >= MAX_DEGREE || degree[b] >= MAX_DEGREE))
                    r.status = STATUS_FULL;
                else begin
                    nbr[a][degree[a][3:0]] = b;
                    degree[a]++;
                    nbr[b][degree[b][3:0]] = a;
                    degree[b]++;
                end
            end
            KIND_NEW_PASS: drop_colors();
            KIND_COLOR: begin
                if (a >= lim) r.status = STATUS_RANGE;
                else begin
                    deg = int'(degree[a]);
                    foreach (taken[i]) taken[i] = 0;
                    for (int j = 0; j < deg; j++) begin
                        n = int'(vcolor[nbr[a][j]]);
                        if (n != 0 && n <= deg) taken[n] = 1;
                    end
                    c = deg + 1;
                    for (int j = 1; j <= deg; j++)
                        if (!taken[j]) begin
                            c = j;
                            break;
                        end
                    vcolor[a] = 5'(c);
                    if (c > int'(pass_hi)) pass_hi = 5'(c);
                    r.color = 5'(c);
                end
            end
            default: begin
                foreach (degree[i]) degree[i] = '0;
                drop_colors();
            end
        endcase
        r.used = pass_hi;
        return r;
    endfunction

    // Directed table; chk marks rows whose outcome is typed in.
    typedef struct {
        t_kind      k;
        logic [7:0] a;
        logic [7:0] b;
        bit         chk;
        t_outcome   want;
    } t_row;

    t_row directed [] = '{
        '{KIND_COLOR,    8'd0,   8'd0,   1, '{STATUS_OK, 5'd1, 5'd1}},
        '{KIND_NEW_PASS, 8'd0,   8'd0,   1, '{STATUS_OK, 5'd0, 5'd0}},
        '{KIND_ADD_EDGE, 8'd255, 8'd0,   1, '{STATUS_OK, 5'd0, 5'd0}},
        '{KIND_ADD_EDGE, 8'd0,   8'd0,   1, '{STATUS_OK, 5'd0, 5'd0}},
        '{KIND_ADD_EDGE, 8'd1,   8'd0,   0, '0},
        '{KIND_ADD_EDGE, 8'd1,   8'd0,   0, '0},
        '{KIND_COLOR,    8'd0,   8'd0,   0, '0},
        '{KIND_COLOR,    8'd1,   8'd0,   0, '0},
        '{KIND_COLOR,    8'd255, 8'd0,   0, '0},
        '{KIND_COLOR,    8'd0,   8'd0,   0, '0},
        '{KIND_ADD_EDGE, 8'd170, 8'd85,  0, '0},
        '{KIND_ADD_EDGE, 8'd85,  8'd170, 0, '0},
        '{KIND_COLOR,    8'd170, 8'd0,   0, '0},
        '{KIND_CLEAR,    8'd255, 8'd255, 1, '{STATUS_OK, 5'd0, 5'd0}},
        '{KIND_COLOR,    8'd255, 8'd255, 1, '{STATUS_OK, 5'd1, 5'd1}}
    };

    // Rows run while the limit is small (8): range errors, an in-range color
    // and a new pass; the pass still holds color 1 from the end of the directed table
    t_row ranged [] = '{
        '{KIND_ADD_EDGE, 8'd8,   8'd0,   1, '{STATUS_RANGE, 5'd0, 5'd1}},
        '{KIND_ADD_EDGE, 8'd0,   8'd255, 1, '{STATUS_RANGE, 5'd0, 5'd1}},
        '{KIND_COLOR,    8'd8,   8'd0,   1, '{STATUS_RANGE, 5'd0, 5'd1}},
        '{KIND_COLOR,    8'd7,   8'd0,   1, '{STATUS_OK, 5'd1, 5'd1}},
        '{KIND_NEW_PASS, 8'd0,   8'd0,   1, '{STATUS_OK, 5'd0, 5'd0}}
    };

    // Random gap: mostly short, a few long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    bit steady;   // stretches with no idling

    // Hand one request to the block and record its expected outcome.
    // Valid stays high into the next request when there is no gap.
    task automatic send_request(t_kind k, logic [7:0] a, logic [7:0] b, bit chk,
                                t_outcome want);
        t_outcome pred;
        int g;
        g = steady ? 0 : gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        pred = color_engine(k, a, b);
        if (chk && pred !== want)
            $display("%0t: table row disagrees with predictor: %h vs %h",
                     $time, want, pred);
        expected_q.push_back(chk ? want : pred);
        i_valid <= 1'b1;
        i_kind <= k;
        i_vertex_a <= a;
        i_vertex_b <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic run_rows(ref t_row rows []);
        foreach (rows[i]) send_request(rows[i].k, rows[i].a, rows[i].b, rows[i].chk,
                                       rows[i].want);
    endtask

    // Wait for every expected result, then hold off for the block to settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [8:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_VERTEX_COUNT;
        pwdata <= {23'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        vlimit = v;
    endtask

    // Random phase: edge adds and colorings on vertices below span, interleaved with new passes and clears.
    task automatic random_phase(int items, int span);
        int p, hi;
        t_kind k;
        logic [7:0] a, b;
        hi = (span > 1) ? span - 1 : 0;
        for (int i = 0; i < items; i++) begin
            if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
            p = $urandom_range(0, 99);
            a = 8'($urandom_range(0, hi));
            b = 8'($urandom_range(0, hi));
            if (p < 45) k = KIND_ADD_EDGE;
            else if (p < 88) k = KIND_COLOR;
            else if (p < 95) k = KIND_NEW_PASS;
            else if (p < 97) k = KIND_CLEAR;
            else begin
                // noise: any index, any kind
                k = t_kind'($urandom_range(0, 3));
                a = 8'($urandom_range(0, 255));
                b = 8'($urandom_range(0, 255));
            end
            send_request(k, a, b, 0, '0);
        end
    endtask

    // Result side: random stalls, compare against the oldest expectation.
    initial begin
        t_outcome got, want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got = '{o_status, o_color, o_colors_used};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                        errors++;
                    end
                    if (got.color !== want.color) begin
                        $display("%0t: color expected %0d actual %0d", $time,
                                 want.color, got.color);
                        errors++;
                    end
                    if (got.used !== want.used) begin
                        $display("%0t: colors_used expected %0d actual %0d", $time,
                                 want.used, got.used);
                        errors++;
                    end
                end
            end
            i_stall <= (!steady && $urandom_range(0, 99) < 25) ||
                       ($urandom_range(0, 199) == 0);
        end
    end

    initial begin
        vlimit = VERTEX_COUNT_RESET;
        foreach (degree[i]) degree[i] = '0;
        drop_colors();
        steady = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_rows(directed);
        drain();
        write_limit(9'd8);
        run_rows(ranged);
        random_phase(500, 10);     // dense: lists fill, many colors
        drain();
        write_limit(9'd1);         // limit of one vertex; stale neighbors remain
        random_phase(100, 4);
        drain();
        write_limit(9'd511);       // above MAX_VERTICES
        send_request(KIND_CLEAR, 8'd0, 8'd0, 0, '0);
        random_phase(700, 40);
        drain();
        write_limit(9'd256);
        random_phase(700, 256);
        drain();
        if (errors == 0)
            $display("greedy_graph_coloring_test: done, clean");
        else
            $display("greedy_graph_coloring_test: done, errors");
        $finish;
    end

    // Hard stop
    initial begin
        #4_000_000;
        $display("greedy_graph_coloring_test: done, errors");
        $finish;
    end

endmodule

// File: files.f
sv/gcol_pkg.sv
sv/gcol_ram.sv
sv/greedy_graph_coloring.sv
tb/greedy_graph_coloring_test.sv
